// File: hw/rtl/lidar_frame_parser_crc8_macros.svh
// Assertion macros for the frame parser.
`ifndef LIDAR_FRAME_PARSER_CRC8_MACROS_SVH
`define LIDAR_FRAME_PARSER_CRC8_MACROS_SVH
// Implication checked every clock, off during reset.
`define LFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfp assertion failed");
// Next-cycle implication, off during reset.
`define LFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfp assertion failed");
`endif

// File: hw/rtl/lfp_pkg.sv
// Shared types and constants of the frame parser.
package lfp_pkg;
  localparam int FRAME_BYTES      = 47;
  localparam int POINTS_PER_FRAME = 12;
  localparam int AW               = 6;
  localparam logic [7:0] CRC_POLY = 8'h4D;
  localparam int POINT_BASE       = 6;
  localparam int END_POS          = 42;
  localparam int STAMP_POS        = 44;
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_VER   = 2'd1;
  localparam logic [1:0] KIND_CRC   = 2'd2;
  localparam logic CFG_HEADER  = 1'b0;
  localparam logic CFG_VERSION = 1'b1;
  localparam int QDEPTH = 2;

  // One CRC-8 byte step, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] x;
    x = c ^ d;
    for (int b = 0; b < 8; b++) begin
      x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  point_index;
    logic [15:0] distance_mm;
    logic [7:0]  intensity;
    logic [15:0] speed;
    logic [15:0] start_angle;
    logic [15:0] end_angle;
    logic [15:0] stamp;
    logic        last;
    logic [31:0] good_frames;
    logic [31:0] crc_fail_count;
    logic [31:0] version_fail_count;
  } result_t;
endpackage

// File: hw/rtl/lfp_ram.sv
// Generic single-port-write RAM with registered read.
module lfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 47
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/lfp_front.sv
// Front part: collect bytes, check the frame, resync, and emit result words.
module lfp_front import lfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  header_byte,
  input  logic [7:0]  version_length_byte,
  output logic        q_push,
  input  logic        q_full,
  output result_t     q_data,
  output logic        busy
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRC  = 3'd1;
  localparam logic [2:0] S_FLD  = 3'd2;
  localparam logic [2:0] S_PT   = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_MOVE = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] fill;
  logic [AW-1:0] rptr;      // address presented to the RAM
  logic          rvalid;    // rdata corresponds to raddr_q
  logic [AW-1:0] raddr_q;
  logic [7:0]    crc;
  logic [7:0]    b1;
  logic [15:0]   speed, start_angle, end_angle, stamp;
  logic [7:0]    dlo, dhi;
  logic [3:0]    pidx;
  logic [1:0]    phase;
  logic [1:0]    err_kind;
  logic [31:0]   good_cnt, crc_cnt, ver_cnt;
  logic [AW-1:0] src, dst;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  lfp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic take;
  assign full = (state != S_IDLE);
  assign take = push && (state == S_IDLE);
  assign busy = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = fill;
    wdata = rx_byte;
    raddr = rptr;
    if (take && (fill != '0 || rx_byte == header_byte)) begin
      we = 1'b1;
    end else if (state == S_MOVE && rvalid) begin
      we    = 1'b1;
      waddr = dst;
      wdata = rdata;
    end
  end

  always_comb begin
    q_data                    = '0;
    q_data.good_frames        = good_cnt;
    q_data.crc_fail_count     = crc_cnt;
    q_data.version_fail_count = ver_cnt;
    q_data.last               = 1'b1;
    q_push                    = 1'b0;
    if (state == S_ERR) begin
      q_data.kind = err_kind;
      q_push      = !q_full;
    end else if (state == S_PT && phase == 2'd3) begin
      q_data.kind        = KIND_POINT;
      q_data.point_index = pidx;
      q_data.distance_mm = {dhi, dlo};
      q_data.intensity   = rdata;
      q_data.speed       = speed;
      q_data.start_angle = start_angle;
      q_data.end_angle   = end_angle;
      q_data.stamp       = stamp;
      q_data.last        = (pidx == 4'(POINTS_PER_FRAME - 1));
      q_push             = !q_full;
    end
  end

  always_ff @(posedge clk) begin
    raddr_q <= rptr;
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      good_cnt <= '0;
      crc_cnt  <= '0;
      ver_cnt  <= '0;
      rvalid   <= 1'b0;
      rptr     <= '0;
      phase    <= '0;
      pidx     <= '0;
      err_kind <= KIND_VER;
      src      <= '0;
      dst      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && we) begin
            if (fill == AW'(FRAME_BYTES - 1)) begin
              // frame complete: walk the buffer for CRC and fields
              fill   <= fill + 1'b1;
              state  <= S_CRC;
              rptr   <= '0;
              rvalid <= 1'b0;
              crc    <= '0;
            end else begin
              fill <= fill + 1'b1;
            end
          end
        end
        S_CRC: begin
          // stream bytes 0..46; rdata is read registered, its address held in raddr_q
          if (rptr != AW'(FRAME_BYTES - 1)) begin
            rptr <= rptr + 1'b1;
          end
          rvalid <= 1'b1;
          if (rvalid) begin
            case (raddr_q)
              AW'(1):             b1 <= rdata;
              AW'(2):             speed[7:0] <= rdata;
              AW'(3):             speed[15:8] <= rdata;
              AW'(4):             start_angle[7:0] <= rdata;
              AW'(5):             start_angle[15:8] <= rdata;
              AW'(END_POS):       end_angle[7:0] <= rdata;
              AW'(END_POS + 1):   end_angle[15:8] <= rdata;
              AW'(STAMP_POS):     stamp[7:0] <= rdata;
              AW'(STAMP_POS + 1): stamp[15:8] <= rdata;
              default: ;
            endcase
            if (raddr_q != AW'(FRAME_BYTES - 1)) begin
              crc <= crc8_step(crc, rdata);
            end else begin
              rvalid <= 1'b0;
              if (b1 != version_length_byte) begin
                ver_cnt  <= ver_cnt + 1'b1;
                err_kind <= KIND_VER;
                state    <= S_ERR;
              end else if (crc != rdata) begin
                crc_cnt  <= crc_cnt + 1'b1;
                err_kind <= KIND_CRC;
                state    <= S_ERR;
              end else begin
                good_cnt <= good_cnt + 1'b1;
                state    <= S_PT;
                pidx     <= '0;
                phase    <= '0;
                rptr     <= AW'(POINT_BASE);
              end
            end
          end
        end
        S_PT: begin
          // phase 0: addr lo issued; 1: lo back; 2: hi back; 3: intensity back, emit
          case (phase)
            2'd0: begin rptr <= rptr + 1'b1; phase <= 2'd1; end
            2'd1: begin dlo <= rdata; rptr <= rptr + 1'b1; phase <= 2'd2; end
            2'd2: begin dhi <= rdata; phase <= 2'd3; end
            default: begin
              if (!q_full) begin
                if (pidx == 4'(POINTS_PER_FRAME - 1)) begin
                  fill  <= '0;
                  state <= S_IDLE;
                end else begin
                  pidx  <= pidx + 1'b1;
                  rptr  <= rptr + 1'b1;
                  phase <= 2'd0;
                end
              end
            end
          endcase
        end
        S_ERR: begin
          if (!q_full) begin
            state  <= S_SCAN;
            rptr   <= AW'(1);
            rvalid <= 1'b0;
          end
        end
        S_SCAN: begin
          // look for the first header byte at position 1 or later
          rvalid <= 1'b1;
          if (rptr != AW'(FRAME_BYTES - 1)) begin
            rptr <= rptr + 1'b1;
          end
          if (rvalid) begin
            if (rdata == header_byte) begin
              src    <= raddr_q;
              dst    <= '0;
              rptr   <= raddr_q;
              rvalid <= 1'b0;
              state  <= S_MOVE;
            end else if (raddr_q == AW'(FRAME_BYTES - 1)) begin
              fill  <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_MOVE: begin
          // copy bytes src..46 down to 0..; one byte a cycle
          rvalid <= 1'b1;
          if (rptr != AW'(FRAME_BYTES - 1)) begin
            rptr <= rptr + 1'b1;
          end
          if (rvalid) begin
            dst <= dst + 1'b1;
            if (raddr_q == AW'(FRAME_BYTES - 1)) begin
              fill   <= AW'(FRAME_BYTES) - src;
              rvalid <= 1'b0;
              state  <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/lfp_queue.sv
// Short result queue between the front part and the result port.
module lfp_queue import lfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  result_t wdata,
  output logic    qfull,
  input  logic    rd,
  output logic    qempty,
  output result_t rdata
);
  result_t     slot [QDEPTH];
  logic        wp, rp;
  logic [1:0]  cnt;
  assign qfull  = (cnt == 2'(QDEPTH));
  assign qempty = (cnt == '0);
  assign rdata  = slot[rp];
  always_ff @(posedge clk) begin
    if (wr && !qfull) begin
      slot[wp] <= wdata;
    end
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr && !qfull) wp <= wp + 1'b1;
      if (rd && !qempty) rp <= rp + 1'b1;
      cnt <= cnt + 2'(wr && !qfull) - 2'(rd && !qempty);
    end
  end
endmodule

// File: hw/rtl/lidar_frame_parser_crc8.sv
// Top level of the CRC-8 checked fixed-length frame parser.
//
//  channel   handshake        data
//  input     push / full      rx_byte
//  result    pop / empty      kind .. version_fail_count
//  config    cfg_we           cfg_index, cfg_data
//
// A byte that does not complete a frame leaves the block idle and ready for the
// next. The 47th byte starts a walk over the frame buffer RAM (one read port):
// a pass over all bytes for the CRC and fields, then one word per point, or on
// rejection the error word, a header scan from byte 1 on and a copy down of up
// to 46 bytes, one a cycle. Full stays high for the whole walk.
// Reset (rst, synchronous) empties the buffer, queue and counters; the buffer
// itself is not cleared. A full result queue stalls the walk at a point or error word.
module lidar_frame_parser_crc8 import lfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [3:0]  point_index,
  output logic [15:0] distance_mm,
  output logic [7:0]  intensity,
  output logic [15:0] speed,
  output logic [15:0] start_angle,
  output logic [15:0] end_angle,
  output logic [15:0] stamp,
  output logic        last,
  output logic [31:0] good_frames,
  output logic [31:0] crc_fail_count,
  output logic [31:0] version_fail_count
);
`include "lidar_frame_parser_crc8_macros.svh"

  logic [7:0] header_byte, version_length_byte;
  logic       q_push, q_full, busy;
  result_t    q_in, q_out;

  // hold the two configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte         <= 8'd84;
      version_length_byte <= 8'd44;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HEADER) header_byte <= cfg_data;
      else                         version_length_byte <= cfg_data;
    end
  end

  lfp_front u_front (
    .clk, .rst, .push, .full, .rx_byte, .header_byte, .version_length_byte,
    .q_push, .q_full, .q_data(q_in), .busy
  );

  lfp_queue u_queue (
    .clk, .rst, .wr(q_push), .wdata(q_in), .qfull(q_full),
    .rd(pop), .qempty(empty), .rdata(q_out)
  );

  assign kind               = q_out.kind;
  assign point_index        = q_out.point_index;
  assign distance_mm        = q_out.distance_mm;
  assign intensity          = q_out.intensity;
  assign speed              = q_out.speed;
  assign start_angle        = q_out.start_angle;
  assign end_angle          = q_out.end_angle;
  assign stamp              = q_out.stamp;
  assign last               = q_out.last;
  assign good_frames        = q_out.good_frames;
  assign crc_fail_count     = q_out.crc_fail_count;
  assign version_fail_count = q_out.version_fail_count;

  `LFP_ASSERT_IMP(a_push_room, q_push, !q_full)
  `LFP_ASSERT_IMP(a_full_busy, full, busy)
  `LFP_ASSERT_NEXT(a_err_last, q_push && q_in.kind != KIND_POINT, $past(q_in.last))
endmodule

// File: tb/tb_lidar_frame_parser_crc8.sv
// Self-checking bench for the CRC-8 checked fixed-length frame parser.
module tb_lidar_frame_parser_crc8 import lfp_pkg::*; ();

  localparam int   CYCLE_LIMIT = 600000;
  localparam int   SETTLE      = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  point_index;
  logic [15:0] distance_mm;
  logic [7:0]  intensity;
  logic [15:0] speed;
  logic [15:0] start_angle;
  logic [15:0] end_angle;
  logic [15:0] stamp;
  logic        last;
  logic [31:0] good_frames;
  logic [31:0] crc_fail_count;
  logic [31:0] version_fail_count;

  lidar_frame_parser_crc8 DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a mirror of the frame buffer, fill level and counters.
  logic [7:0]  frame_mirror [FRAME_BYTES];
  int          fill_level;
  logic [31:0] n_good, n_crc_bad, n_ver_bad;
  logic [7:0]  hdr_value, ver_value;

  result_t     expected_results[$];
  logic [7:0]  pending_bytes[$];
  int          mismatches;
  int          cycles = 0;
  bit          stim_done;

  // Sending-side helpers also used to build well-formed frames.
  function automatic logic [7:0] frame_crc(input logic [7:0] f[FRAME_BYTES]);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      c = c ^ f[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Drop everything before the first later header, or empty the buffer.
  function automatic void resync_mirror();
    for (int i = 1; i < fill_level; i++) begin
      if (frame_mirror[i] == hdr_value) begin
        for (int j = 0; j < fill_level - i; j++) frame_mirror[j] = frame_mirror[j + i];
        fill_level = fill_level - i;
        return;
      end
    end
    fill_level = 0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    result_t r;
    if (fill_level == 0 && b != hdr_value) return;
    frame_mirror[fill_level] = b;
    fill_level++;
    if (fill_level < FRAME_BYTES) return;
    r = '0;
    if (frame_mirror[1] != ver_value) begin
      n_ver_bad++;
      r.kind = KIND_VER;
    end else if (frame_crc(frame_mirror) != frame_mirror[FRAME_BYTES - 1]) begin
      n_crc_bad++;
      r.kind = KIND_CRC;
    end
    if (r.kind != KIND_POINT) begin
      resync_mirror();
      r.last = 1'b1;
      r.good_frames = n_good;
      r.crc_fail_count = n_crc_bad;
      r.version_fail_count = n_ver_bad;
      expected_results.push_back(r);
      return;
    end
    n_good++;
    for (int i = 0; i < POINTS_PER_FRAME; i++) begin
      r = '0;
      r.kind = KIND_POINT;
      r.point_index = 4'(i);
      r.distance_mm = {frame_mirror[POINT_BASE + 3*i + 1], frame_mirror[POINT_BASE + 3*i]};
      r.intensity = frame_mirror[POINT_BASE + 3*i + 2];
      r.speed = {frame_mirror[3], frame_mirror[2]};
      r.start_angle = {frame_mirror[5], frame_mirror[4]};
      r.end_angle = {frame_mirror[END_POS + 1], frame_mirror[END_POS]};
      r.stamp = {frame_mirror[STAMP_POS + 1], frame_mirror[STAMP_POS]};
      r.last = (i == POINTS_PER_FRAME - 1);
      r.good_frames = n_good;
      r.crc_fail_count = n_crc_bad;
      r.version_fail_count = n_ver_bad;
      expected_results.push_back(r);
    end
    fill_level = 0;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Queue one frame: good, bad version byte, or bad CRC, with random or fixed-fill payload.
  task automatic queue_frame(input int flavour, input bit extremes, input logic [7:0] fill);
    logic [7:0] f[FRAME_BYTES];
    for (int i = 0; i < FRAME_BYTES; i++) f[i] = extremes ? fill : 8'($urandom);
    f[0] = hdr_value;
    f[1] = (flavour == 1) ? ver_value ^ 8'($urandom_range(1, 255)) : ver_value;
    f[FRAME_BYTES - 1] = frame_crc(f);
    if (flavour == 2) f[FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_BYTES; i++) pending_bytes.push_back(f[i]);
  endtask

  // Wait for the queue to drain and the block to settle, then write a register.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    wait (pending_bytes.size() == 0 && !push);
    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEADER) hdr_value = val; else ver_value = val;
  endtask

  task automatic random_phase(input int n_frames);
    int p;
    for (int k = 0; k < n_frames; k++) begin
      p = $urandom_range(0, 99);
      if (p < 65) queue_frame(0, 1'b0, 8'h00);
      else if (p < 75) queue_frame(1, 1'b0, 8'h00);
      else if (p < 85) queue_frame(2, 1'b0, 8'h00);
      else begin
        // noise, often with stray headers to exercise the resync scan
        repeat ($urandom_range(1, 20))
          pending_bytes.push_back($urandom_range(0, 3) == 0 ? hdr_value : 8'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) frame_mirror[i] = '0;
    fill_level = 0;
    n_good = '0; n_crc_bad = '0; n_ver_bad = '0;
    hdr_value = 8'd84; ver_value = 8'd44;
    mismatches = 0;
    stim_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: junk before a header, then an all-zero payload,
    // a bad version byte and a bad CRC at reset settings.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    queue_frame(0, 1'b1, 8'h00);
    queue_frame(1, 1'b0, 8'h00);
    queue_frame(2, 1'b0, 8'h00);
    random_phase(1);
    // Extremes of both registers.
    write_reg(CFG_HEADER, 8'h00);
    write_reg(CFG_VERSION, 8'hFF);
    queue_frame(0, 1'b1, 8'h00);
    random_phase(1);
    write_reg(CFG_HEADER, 8'hFF);
    write_reg(CFG_VERSION, 8'h00);
    queue_frame(0, 1'b1, 8'hFF);
    write_reg(CFG_HEADER, 8'($urandom));
    write_reg(CFG_VERSION, 8'($urandom));
    random_phase(1);
    write_reg(CFG_HEADER, 8'd84);
    write_reg(CFG_VERSION, 8'd44);
    random_phase(1);
    wait (pending_bytes.size() == 0 && !push);
    stim_done = 1'b1;
  end

  // Driver: hold push and byte until accepted, then advance or idle.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_byte(rx_byte);
        if (pending_bytes.size() != 0 && send_gap == 0 && gap_len() == 0) begin
          rx_byte <= pending_bytes.pop_front();
        end else begin
          push <= 1'b0;
          send_gap <= gap_len();
        end
      end else if (!push) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_bytes.size() != 0) begin
          push <= 1'b1;
          rx_byte <= pending_bytes.pop_front();
        end
      end
    end
  end

  // Monitor: check each accepted word against the oldest expectation.
  int pop_gap = 0;
  result_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        got = '{kind, point_index, distance_mm, intensity, speed, start_angle,
                end_angle, stamp, last, good_frames, crc_fail_count, version_fail_count};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) pop_gap <= gap_len();
      end
    end
  end

  // Finish: drain, settle, then verdict; cycle limit as a watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lfp_pkg.sv
hw/rtl/lfp_ram.sv
hw/rtl/lfp_front.sv
hw/rtl/lfp_queue.sv
hw/rtl/lidar_frame_parser_crc8.sv
tb/tb_lidar_frame_parser_crc8.sv
